FILE: hdl/ptps_pkg.sv
// Package with the shared types and constants of the process table scheduler.
package ptps_pkg;

  localparam int Entries  = 64;
  localparam int IdxBits  = 6;
  localparam int CntBits  = 7;
  localparam int PidBits  = 16;
  localparam int PrioBits = 8;

  localparam logic [2:0] StReady   = 3'd0;
  localparam logic [2:0] StRunning = 3'd1;
  localparam logic [2:0] StZombie  = 3'd2;

  localparam logic [2:0] ModeCreate  = 3'd0;
  localparam logic [2:0] ModeRemove  = 3'd1;
  localparam logic [2:0] ModeSetSt   = 3'd2;
  localparam logic [2:0] ModeSetPrio = 3'd3;
  localparam logic [2:0] ModeSwitch  = 3'd4;
  localparam logic [2:0] ModeSched   = 3'd5;
  localparam logic [2:0] ModeExit    = 3'd6;
  localparam logic [2:0] ModeQuery   = 3'd7;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatBadState = 2'd2;
  localparam logic [1:0] StatFull     = 2'd3;

  localparam logic [1:0] RegDefaultPrio = 2'd0;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] target_pid;
    logic [2:0]  new_state;
    logic [7:0]  new_priority;
    logic [31:0] exit_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  op_status;
    logic [15:0] pid_out;
    logic [15:0] current_pid;
    logic [2:0]  entry_state;
    logic [7:0]  entry_priority;
    logic [31:0] entry_exit_code;
    logic [6:0]  process_count;
  } out_item_t;

  // One table entry as kept in the RAM.
  typedef struct packed {
    logic [15:0] pid;
    logic [2:0]  state;
    logic [7:0]  prio;
    logic [31:0] code;
  } entry_t;

  localparam int EntryBits = $bits(entry_t);

endpackage

FILE: hdl/ptps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ptps_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/process_table_priority_scheduler.sv
// Top level of the process table engine with a fixed-priority scheduler.
//
// A request is a transaction on the in_ channel: drive in_item and raise start;
// it is taken at a clock edge where start is high and busy is low. Busy stays
// high while the request runs. The single result is shown on out_item with
// out_valid high for one cycle, the first cycle with busy low again; the
// receiver cannot stall, so the result is always taken.
// Every request scans the 64-entry table once through one RAM read port, one
// entry per cycle, feeding a single shared compare unit (pid match, first free
// slot and best ready priority at once). A decode step and a result step follow;
// schedule and exit add steps to read back, demote or retire the current entry
// and promote the chosen one. The next request can be accepted at the edge that
// ends the cycle with out_valid high; before that, busy stays high and no new
// request is taken.
// The default priority register sits at APB address 0 of the configuration port and is
// read back through prdata. Synchronous active-low reset empties the table
// (valid bits in flip-flops), makes idle current, sets the next pid to 1 and
// the default priority to 128. The RAM contents need no clearing.
module process_table_priority_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ptps_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ptps_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ptps_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_RDA   = 7'b0001000,
    S_WRA   = 7'b0010000,
    S_WRB   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]        dprio_r;
  logic [Entries-1:0] used_r;
  logic [CntBits-1:0] cur_r;     // Entries means idle
  logic [2:0]        idle_st_r;
  logic [PidBits-1:0] next_pid_r;
  logic [CntBits-1:0] count_r;
  in_item_t          req_r;

  logic [CntBits-1:0] scan_r;    // read address sent, Entries when done
  logic              rvalid_r;
  logic [IdxBits-1:0] ridx_r;
  logic              match_ok_r, free_ok_r, pick_ok_r;
  logic [IdxBits-1:0] match_r, free_r, pick_r;
  logic [PrioBits-1:0] best_r;
  entry_t            match_e_r, cur_e_r;
  logic [15:0]       cur_pid_r;  // pid shown as current
  logic              wr_pick_r;
  out_item_t         out_r;
  logic              out_v_r;
  out_item_t         dec_res;

  // RAM ports.
  logic              we;
  logic [IdxBits-1:0] waddr, raddr;
  entry_t            wdata, rdata;

  ptps_ram #(.Width(EntryBits), .Depth(Entries)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == RegDefaultPrio) ? {24'd0, dprio_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dprio_r <= 8'd128;
    end else if (psel && penable && pwrite && paddr == RegDefaultPrio) begin
      dprio_r <= pwdata[7:0];
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  logic is_cur_slot;
  assign is_cur_slot = (cur_r < CntBits'(Entries));

  // Read address: scan index, or the current slot in the read-back step.
  always_comb begin
    raddr = scan_r[IdxBits-1:0];
    if (state_r == S_RDA) begin
      raddr = cur_r[IdxBits-1:0];
    end
  end

  // Result fields decided right after the scan.
  always_comb begin
    dec_res = '0;
    dec_res.current_pid   = cur_pid_r;
    dec_res.process_count = count_r;
    case (req_r.mode) inside
      ModeCreate: begin
        if (free_ok_r) begin
          dec_res.pid_out       = next_pid_r;
          dec_res.process_count = count_r + 1'b1;
          // A freed current slot that is reused now shows the new pid.
          if (is_cur_slot && cur_r[IdxBits-1:0] == free_r) begin
            dec_res.current_pid = next_pid_r;
          end
        end else begin
          dec_res.op_status = StatFull;
          dec_res.pid_out   = '1;
        end
      end
      ModeRemove: begin
        if (match_ok_r) dec_res.process_count = count_r - 1'b1;
        else dec_res.op_status = StatNotFound;
      end
      ModeSwitch: begin
        if (!match_ok_r) dec_res.op_status = StatNotFound;
        else if (match_e_r.state != StReady) dec_res.op_status = StatBadState;
        else dec_res.current_pid = match_e_r.pid;
      end
      ModeQuery: begin
        if (match_ok_r) begin
          dec_res.entry_state     = match_e_r.state;
          dec_res.entry_priority  = match_e_r.prio;
          dec_res.entry_exit_code = match_e_r.code;
        end else dec_res.op_status = StatNotFound;
      end
      ModeSetSt, ModeSetPrio: begin
        if (!match_ok_r) dec_res.op_status = StatNotFound;
      end
      default: ;
    endcase
  end

  // Write port control and state sequencing.
  always_comb begin
    entry_t e;
    state_nxt = state_r;
    we    = 1'b0;
    waddr = match_r;
    e     = match_e_r;
    wdata = e;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_SCAN;
      S_SCAN: if (scan_r == CntBits'(Entries) && !rvalid_r) state_nxt = S_DEC;
      S_DEC: begin
        // Single-entry updates.
        state_nxt = S_DONE;
        case (req_r.mode) inside
          ModeCreate: if (free_ok_r) begin
            we    = 1'b1;
            waddr = free_r;
            wdata = '{pid: next_pid_r, state: StReady, prio: dprio_r, code: 32'd0};
          end
          ModeSetSt: if (match_ok_r) begin
            we = 1'b1; e.state = req_r.new_state; wdata = e;
          end
          ModeSetPrio: if (match_ok_r) begin
            we = 1'b1; e.prio = req_r.new_priority; wdata = e;
          end
          ModeSwitch: if (match_ok_r && match_e_r.state == StReady) begin
            we = 1'b1; e.state = StRunning; wdata = e;
          end
          ModeSched, ModeExit: state_nxt = S_RDA;
          default: ;
        endcase
      end
      S_RDA: state_nxt = S_WRA;
      S_WRA: begin
        // Demote or retire the current entry.
        if (is_cur_slot) begin
          e = rdata;
          waddr = cur_r[IdxBits-1:0];
          if (req_r.mode == ModeExit) begin
            we = 1'b1; e.code = req_r.exit_value; e.state = StZombie;
          end else if (rdata.state == StRunning) begin
            we = 1'b1; e.state = StReady;
          end
          wdata = e;
        end
        state_nxt = S_WRB;
      end
      S_WRB: begin
        // Promote the chosen entry; cur_e_r holds its data.
        if (wr_pick_r) begin
          we = 1'b1; waddr = pick_r; e = cur_e_r; e.state = StRunning; wdata = e;
        end
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      used_r     <= '0;
      cur_r      <= CntBits'(Entries);
      idle_st_r  <= StReady;
      next_pid_r <= 16'd1;
      count_r    <= '0;
      out_v_r    <= 1'b0;
      scan_r     <= '0;
      rvalid_r   <= 1'b0;
      cur_pid_r  <= '0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          req_r      <= in_item;
          scan_r     <= '0;
          rvalid_r   <= 1'b0;
          match_ok_r <= 1'b0;
          free_ok_r  <= 1'b0;
          pick_ok_r  <= 1'b0;
        end
        S_SCAN: begin
          // Issue one read per cycle; compare the entry that comes back.
          rvalid_r <= (scan_r != CntBits'(Entries));
          ridx_r   <= scan_r[IdxBits-1:0];
          if (scan_r != CntBits'(Entries)) scan_r <= scan_r + 1'b1;
          if (rvalid_r) begin
            if (!free_ok_r && !used_r[ridx_r]) begin
              free_ok_r <= 1'b1; free_r <= ridx_r;
            end
            if (!match_ok_r && used_r[ridx_r] && rdata.pid == req_r.target_pid) begin
              match_ok_r <= 1'b1; match_r <= ridx_r; match_e_r <= rdata;
            end
            // The exiting entry becomes zombie and is not a candidate.
            if (used_r[ridx_r] && rdata.state == StReady
                && !(req_r.mode == ModeExit && is_cur_slot
                     && cur_r[IdxBits-1:0] == ridx_r)
                && (!pick_ok_r || rdata.prio > best_r)) begin
              pick_ok_r <= 1'b1; pick_r <= ridx_r; best_r <= rdata.prio;
              cur_e_r <= rdata;
            end
          end
        end
        S_DEC: begin
          out_r <= dec_res;
          case (req_r.mode)
            ModeCreate: begin
              if (free_ok_r) begin
                used_r[free_r] <= 1'b1;
                count_r        <= count_r + 1'b1;
                next_pid_r     <= next_pid_r + 1'b1;
                if (is_cur_slot && cur_r[IdxBits-1:0] == free_r) cur_pid_r <= next_pid_r;
              end
            end
            ModeRemove: begin
              if (match_ok_r) begin
                used_r[match_r] <= 1'b0;
                count_r         <= count_r - 1'b1;
              end
            end
            ModeSwitch: begin
              if (match_ok_r && match_e_r.state == StReady) begin
                cur_r     <= {1'b0, match_r};
                cur_pid_r <= match_e_r.pid;
              end
            end
            default: ;
          endcase
        end
        S_WRA: begin
          if (!is_cur_slot) begin
            if (req_r.mode == ModeExit) idle_st_r <= StZombie;
            else if (idle_st_r == StRunning) idle_st_r <= StReady;
          end
          wr_pick_r <= pick_ok_r;
        end
        S_WRB: begin
          if (pick_ok_r) begin
            cur_r <= {1'b0, pick_r};
            cur_pid_r <= cur_e_r.pid;
            out_r.current_pid <= cur_e_r.pid;
          end else begin
            idle_st_r <= StRunning;
            cur_r <= CntBits'(Entries);
            cur_pid_r <= '0;
            out_r.current_pid <= '0;
          end
        end
        S_DONE: out_v_r <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: bench/process_table_priority_scheduler_tb.sv
// Self-checking testbench for the process table scheduler: random and directed requests.
module process_table_priority_scheduler_tb;
  import ptps_pkg::*;

  localparam int CycleLimit = 1000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;

  process_table_priority_scheduler u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the process table.
  logic        tbl_used [Entries];
  logic [15:0] tbl_pid [Entries];
  logic [2:0]  tbl_state [Entries];
  logic [7:0]  tbl_prio [Entries];
  logic [31:0] tbl_code [Entries];
  int          cur_slot;
  logic [2:0]  idle_st;
  logic [15:0] pid_next;
  int          used_cnt;
  logic [7:0]  dflt_prio;

  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];
  int        requests_sent;
  int        results_seen;
  int        fail_count;
  int        cycle_count;
  int        gap_left;
  bit        hold_off;

  function automatic int lookup_pid(logic [15:0] pid);
    for (int i = 0; i < Entries; i++)
      if (tbl_used[i] && tbl_pid[i] == pid) return i;
    return -1;
  endfunction

  // Pick the best ready entry, demote the running current one, run the pick.
  task automatic pick_next_process();
    int pick;
    logic [7:0] best;
    pick = -1;
    best = '0;
    for (int i = 0; i < Entries; i++)
      if (tbl_used[i] && tbl_state[i] == StReady && (pick < 0 || tbl_prio[i] > best)) begin
        pick = i;
        best = tbl_prio[i];
      end
    if (cur_slot < Entries) begin
      if (tbl_state[cur_slot] == StRunning) tbl_state[cur_slot] = StReady;
    end else if (idle_st == StRunning) begin
      idle_st = StReady;
    end
    if (pick < 0) begin
      idle_st = StRunning;
      cur_slot = Entries;
    end else begin
      tbl_state[pick] = StRunning;
      cur_slot = pick;
    end
  endtask

  // Apply one request to the shadow table and return the expected result.
  task automatic apply_request(input in_item_t rq, output out_item_t rs);
    int idx;
    rs = '0;
    case (rq.mode)
      ModeCreate: begin
        idx = -1;
        for (int i = 0; i < Entries; i++)
          if (!tbl_used[i] && idx < 0) idx = i;
        if (idx < 0) begin
          rs.op_status = StatFull;
          rs.pid_out = '1;
        end else begin
          tbl_used[idx] = 1'b1;
          tbl_pid[idx] = pid_next;
          tbl_state[idx] = StReady;
          tbl_prio[idx] = dflt_prio;
          tbl_code[idx] = '0;
          rs.pid_out = pid_next;
          pid_next = pid_next + 16'd1;
          used_cnt++;
        end
      end
      ModeRemove: begin
        idx = lookup_pid(rq.target_pid);
        if (idx < 0) rs.op_status = StatNotFound;
        else begin
          tbl_used[idx] = 1'b0;
          used_cnt--;
        end
      end
      ModeSetSt: begin
        idx = lookup_pid(rq.target_pid);
        if (idx < 0) rs.op_status = StatNotFound;
        else tbl_state[idx] = rq.new_state;
      end
      ModeSetPrio: begin
        idx = lookup_pid(rq.target_pid);
        if (idx < 0) rs.op_status = StatNotFound;
        else tbl_prio[idx] = rq.new_priority;
      end
      ModeSwitch: begin
        idx = lookup_pid(rq.target_pid);
        if (idx < 0) rs.op_status = StatNotFound;
        else if (tbl_state[idx] != StReady) rs.op_status = StatBadState;
        else begin
          tbl_state[idx] = StRunning;
          cur_slot = idx;
        end
      end
      ModeSched: pick_next_process();
      ModeExit: begin
        if (cur_slot < Entries) begin
          tbl_code[cur_slot] = rq.exit_value;
          tbl_state[cur_slot] = StZombie;
        end else begin
          idle_st = StZombie;
        end
        pick_next_process();
      end
      default: begin
        idx = lookup_pid(rq.target_pid);
        if (idx < 0) rs.op_status = StatNotFound;
        else begin
          rs.entry_state = tbl_state[idx];
          rs.entry_priority = tbl_prio[idx];
          rs.entry_exit_code = tbl_code[idx];
        end
      end
    endcase
    rs.current_pid = (cur_slot < Entries) ? tbl_pid[cur_slot] : 16'd0;
    rs.process_count = used_cnt[6:0];
  endtask

  // Build a request with random content; pids are biased toward live ones.
  function automatic in_item_t random_request(logic [2:0] md);
    in_item_t rq;
    int slot;
    rq.mode = md;
    rq.target_pid = 16'($urandom);
    rq.new_state = 3'($urandom);
    if ($urandom_range(0, 3) != 0) rq.new_state = 3'($urandom_range(0, 2));
    rq.new_priority = 8'($urandom);
    rq.exit_value = $urandom;
    if ($urandom_range(0, 9) < 8) begin
      slot = $urandom_range(0, Entries - 1);
      rq.target_pid = pid_next - 16'($urandom_range(1, 70));
      for (int i = 0; i < Entries; i++)
        if (tbl_used[(slot + i) % Entries] && rq.target_pid != tbl_pid[(slot + i) % Entries]
            && $urandom_range(0, 1) == 0)
          rq.target_pid = tbl_pid[(slot + i) % Entries];
    end
    return rq;
  endfunction

  function automatic in_item_t make_request(logic [2:0] md, logic [15:0] pid,
                                            logic [2:0] st, logic [7:0] pr,
                                            logic [31:0] code);
    in_item_t rq;
    rq.mode = md;
    rq.target_pid = pid;
    rq.new_state = st;
    rq.new_priority = pr;
    rq.exit_value = code;
    return rq;
  endfunction

  // Driver: one request per transaction, random gaps in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      start <= 1'b0;
      requests_sent <= requests_sent + 1;
      gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 80) : $urandom_range(0, 2);
    end else if (!start && gap_left > 0) begin
      gap_left <= gap_left - 1;
    end else if (!start && !hold_off && pending_reqs.size() > 0) begin
      in_item <= pending_reqs.pop_front();
      start <= 1'b1;
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        fail_count <= fail_count + 1;
      end else begin
        out_item_t exp_r;
        exp_r = expected_results.pop_front();
        if (exp_r !== out_item) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_item);
          fail_count <= fail_count + 1;
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Queue a request and its prediction.
  task automatic post_request(input in_item_t rq);
    out_item_t rs;
    apply_request(rq, rs);
    pending_reqs.push_back(rq);
    expected_results.push_back(rs);
  endtask

  // Wait until every queued request has been answered and the block is idle.
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_default_prio(input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegDefaultPrio;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dflt_prio = value;
  endtask

  // Random phase: random modes, with extra creates below 8 used entries and extra removes above 56.
  task automatic random_phase(input int count);
    logic [2:0] md;
    for (int n = 0; n < count; n++) begin
      md = 3'($urandom);
      if (used_cnt < 8 && $urandom_range(0, 2) == 0) md = ModeCreate;
      if (used_cnt > 56 && $urandom_range(0, 2) == 0) md = ModeRemove;
      post_request(random_request(md));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    requests_sent = 0;
    results_seen = 0;
    fail_count = 0;
    cycle_count = 0;
    hold_off = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      tbl_used[i] = 1'b0;
      tbl_pid[i] = '0;
      tbl_state[i] = StReady;
      tbl_prio[i] = '0;
      tbl_code[i] = '0;
    end
    cur_slot = Entries;
    idle_st = StReady;
    pid_next = 16'd1;
    used_cnt = 0;
    dflt_prio = 8'd128;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty-table cases, idle exit, lookups, switch errors.
    post_request(make_request(ModeQuery, 16'd1, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeSched, 16'd0, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeExit, 16'd0, 3'd0, 8'd0, 32'hFFFF_FFFF));
    post_request(make_request(ModeCreate, 16'hFFFF, 3'd7, 8'hFF, 32'd0));
    post_request(make_request(ModeCreate, 16'd0, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeSetPrio, 16'd2, 3'd0, 8'hFF, 32'd0));
    post_request(make_request(ModeSched, 16'd0, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeSwitch, 16'd2, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeSwitch, 16'd1, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeSetSt, 16'd1, 3'd7, 8'd0, 32'd0));
    post_request(make_request(ModeQuery, 16'd1, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeExit, 16'd0, 3'd0, 8'd0, 32'hA5A5_5A5A));
    post_request(make_request(ModeQuery, 16'd2, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeRemove, 16'd1, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeRemove, 16'd1, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeSetPrio, 16'hFFFF, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeSched, 16'd0, 3'd0, 8'd0, 32'd0));
    drain();

    // Extreme default priorities, with a fill to the full table in between.
    write_default_prio(8'd0);
    for (int i = 0; i < 66; i++) post_request(make_request(ModeCreate, 16'd0, 3'd0, 8'd0, 32'd0));
    post_request(make_request(ModeSched, 16'd0, 3'd0, 8'd0, 32'd0));
    drain();
    write_default_prio(8'd255);
    random_phase(300);
    drain();

    // Pause the sender in mid-stream until every sent request is answered.
    random_phase(50);
    while (pending_reqs.size() >= 25) @(posedge clk);
    hold_off = 1'b1;
    while (expected_results.size() != pending_reqs.size()) @(posedge clk);
    repeat (20) @(posedge clk);
    hold_off = 1'b0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_default_prio(8'($urandom));
      random_phase(200);
      drain();
    end

    // Create/remove churn at the default priority.
    write_default_prio(8'd128);
    for (int i = 0; i < 20; i++) begin
      post_request(make_request(ModeCreate, 16'd0, 3'd0, 8'd0, 32'd0));
      post_request(make_request(ModeRemove, pid_next - 16'd1, 3'd0, 8'd0, 32'd0));
    end
    drain();

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
